@@ sv/assert_macros.svh @@
// Assertion macros shared by the stair light sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Condition must never hold.
`define ASSERT_NEVER(lbl, c, r, cond) \
  lbl: assert property (@(posedge c) disable iff (!r) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ sv/sls_pkg.sv @@
// Types, constants and helpers for the stair light sequencer.
package sls_pkg;

  localparam int LVL_W     = 8;
  localparam int NUM_OUT   = 8;
  localparam int TIMER_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam logic [7:0]  MAX_LEVEL_RST   = 8'd120;
  localparam logic [7:0]  LEVEL_TICKS_RST = 8'd10;
  localparam logic [15:0] BLOCK_TICKS_RST = 16'd30000;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TICKS = 2'd2;

  // sequence slots, also bit positions in the progress flags
  typedef logic [1:0] seq_t;
  localparam seq_t SEQ_UP_ON  = 2'd0;
  localparam seq_t SEQ_UP_OFF = 2'd1;
  localparam seq_t SEQ_DN_ON  = 2'd2;
  localparam seq_t SEQ_DN_OFF = 2'd3;

  typedef enum logic [2:0] {
    PH_EVAL,
    PH_UP_ON,
    PH_UP_OFF,
    PH_DN_ON,
    PH_DN_OFF,
    PH_FADE
  } phase_e;

  typedef struct packed {
    logic [7:0]  max_level;
    logic [7:0]  level_ticks;
    logic [15:0] block_ticks;
  } cfg_t;

  typedef struct packed {
    logic is_dark;
    logic motion_bottom;
    logic motion_top;
  } item_t;

  typedef struct packed {
    logic [NUM_OUT-1:0][LVL_W-1:0] level;
    logic                          ramp_busy;
  } result_t;

  function automatic seq_t phase_to_seq(input phase_e ph);
    seq_t s;
    case (ph)
      PH_UP_ON:  s = SEQ_UP_ON;
      PH_UP_OFF: s = SEQ_UP_OFF;
      PH_DN_ON:  s = SEQ_DN_ON;
      PH_DN_OFF: s = SEQ_DN_OFF;
      default:   s = SEQ_UP_ON;
    endcase
    return s;
  endfunction

  function automatic phase_e seq_to_phase(input seq_t s);
    phase_e ph;
    case (s)
      SEQ_UP_ON:  ph = PH_UP_ON;
      SEQ_UP_OFF: ph = PH_UP_OFF;
      SEQ_DN_ON:  ph = PH_DN_ON;
      default:    ph = PH_DN_OFF;
    endcase
    return ph;
  endfunction

  // on-sequences ramp up
  function automatic logic seq_rises(input seq_t s);
    return (s == SEQ_UP_ON) || (s == SEQ_DN_ON);
  endfunction

  // upward sequences walk the index bottom to top
  function automatic logic seq_up(input seq_t s);
    return (s == SEQ_UP_ON) || (s == SEQ_UP_OFF);
  endfunction

endpackage

@@ sv/sls_in_if.sv @@
// Input channel interface: one tick transaction with the sensor levels.
interface sls_in_if;
  logic valid;
  logic ready;
  logic is_dark;
  logic motion_bottom;
  logic motion_top;

  modport source (output valid, output is_dark, output motion_bottom, output motion_top,
                  input ready);
  modport sink (input valid, input is_dark, input motion_bottom, input motion_top,
                output ready);
endinterface

@@ sv/sls_out_if.sv @@
// Result channel interface: step brightness levels and the busy flag.
interface sls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level_step0;
  logic [7:0] level_step1;
  logic [7:0] level_step2;
  logic [7:0] level_step3;
  logic [7:0] level_step4;
  logic [7:0] level_step5;
  logic [7:0] level_step6;
  logic [7:0] level_step7;
  logic       ramp_busy;

  modport source (output valid, output level_step0, output level_step1, output level_step2,
                  output level_step3, output level_step4, output level_step5,
                  output level_step6, output level_step7, output ramp_busy, input ready);
  modport sink (input valid, input level_step0, input level_step1, input level_step2,
                input level_step3, input level_step4, input level_step5,
                input level_step6, input level_step7, input ramp_busy, output ready);
endinterface

@@ sv/stair_light_sequencer_top.sv @@
// Stair light sequencer top level: input register, tick step logic, result register.
// An accepted tick waits in the input register and is stepped once the result register is free.
// Throughput: one tick per cycle unless the sink stalls; the whole tick resolves in one pass of the step logic.
// Reset (rst_n low, synchronous): all steps dark, sequences idle, registers at defaults.
// No clearing pass; the block accepts ticks right after reset.
`include "assert_macros.svh"

module stair_light_sequencer_top #(
  parameter int NUM_STEPS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sls_in_if.sink                              in_ch,
  sls_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [sls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sls_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sls_pkg::cfg_t    cfg_r;
  sls_pkg::item_t   item;
  sls_pkg::result_t result;
  logic             item_valid;
  logic             fire;

  // A held tick is processed when the result register is empty or being drained.
  assign fire = item_valid && (!out_ch.valid || out_ch.ready);

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level   <= sls_pkg::MAX_LEVEL_RST;
      cfg_r.level_ticks <= sls_pkg::LEVEL_TICKS_RST;
      cfg_r.block_ticks <= sls_pkg::BLOCK_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sls_pkg::CFG_MAX_LEVEL:   cfg_r.max_level   <= cfg_wdata[7:0];
        sls_pkg::CFG_LEVEL_TICKS: cfg_r.level_ticks <= cfg_wdata[7:0];
        sls_pkg::CFG_BLOCK_TICKS: cfg_r.block_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Tick transactions land here; ready stays high while the pipe can move.
  sls_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  // All sequencing state; updates once per fired tick.
  sls_step #(
    .NUM_STEPS (NUM_STEPS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg_r),
    .result (result)
  );

  // Result transactions wait here for the sink.
  sls_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire),
    .result (result),
    .out_ch (out_ch)
  );

  // every processed tick must show up as a pending result
  `ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, out_ch.valid)

endmodule

@@ sv/sls_in_stage.sv @@
// Input register: holds one accepted tick until the step logic consumes it.
module sls_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  sls_in_if.sink          in_ch,
  input  logic            fire,
  output logic            item_valid,
  output sls_pkg::item_t  item
);

  logic           valid_r, valid_nxt;
  sls_pkg::item_t item_r;
  logic           accept;

  assign in_ch.ready = !valid_r || fire;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.is_dark       <= in_ch.is_dark;
      item_r.motion_bottom <= in_ch.motion_bottom;
      item_r.motion_top    <= in_ch.motion_top;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ sv/sls_step.sv @@
// Sequencer state and the single-pass next-state logic for one tick.
`include "assert_macros.svh"

module sls_step #(
  parameter int NUM_STEPS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sls_pkg::item_t    item,
  input  sls_pkg::cfg_t     cfg,
  output sls_pkg::result_t  result
);

  localparam int IDX_W = $clog2(NUM_STEPS);
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_STEPS - 1);

  typedef logic [IDX_W-1:0] idx_t;

  logic [NUM_STEPS-1:0]        lit_r, lit_nxt;
  logic [sls_pkg::LVL_W-1:0]   lvl_r [NUM_STEPS];
  logic [sls_pkg::LVL_W-1:0]   lvl_nxt [NUM_STEPS];
  idx_t                        idx_r [4];
  idx_t                        idx_nxt [4];
  logic [3:0]                  prog_r, prog_nxt;
  logic [1:0]                  dir_r, dir_nxt;
  logic [1:0]                  lock_r, lock_nxt;
  logic [sls_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [7:0]                  ramp_r, ramp_nxt;
  logic [7:0]                  hold_r, hold_nxt;
  sls_pkg::phase_e             phase_r, phase_nxt;

  sls_pkg::seq_t cur_seq;
  logic          done;
  logic          run_en;
  logic [2:0]    run_from;
  logic          started;
  logic          pass_end;

  function automatic logic idx_wraps(input sls_pkg::seq_t s, input idx_t ix);
    return sls_pkg::seq_up(s) ? (ix >= TOP_IDX) : (ix == '0);
  endfunction

  function automatic idx_t idx_step(input sls_pkg::seq_t s, input idx_t ix);
    idx_t nx;
    if (sls_pkg::seq_up(s)) begin
      nx = (ix >= TOP_IDX) ? '0 : ix + idx_t'(1);
    end else begin
      nx = (ix == '0) ? TOP_IDX : ix - idx_t'(1);
    end
    return nx;
  endfunction

  assign cur_seq = sls_pkg::phase_to_seq(phase_r);

  // next state
  always_comb begin
    lit_nxt   = lit_r;
    lvl_nxt   = lvl_r;
    idx_nxt   = idx_r;
    prog_nxt  = prog_r;
    dir_nxt   = dir_r;
    lock_nxt  = lock_r;
    timer_nxt = timer_r;
    ramp_nxt  = ramp_r;
    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    done      = 1'b0;
    run_en    = 1'b0;
    run_from  = '0;
    started   = 1'b0;
    pass_end  = 1'b0;

    if (fire) begin
      if (lock_r != 2'b00 && timer_r != sls_pkg::TIMER_MAX) begin
        timer_nxt = timer_r + sls_pkg::TIMER_W'(1);
      end

      if (phase_r == sls_pkg::PH_EVAL) begin
        if (!item.is_dark) begin
          lock_nxt  = 2'b00;
          timer_nxt = '0;
          if (|lit_r) begin
            phase_nxt = sls_pkg::PH_FADE;
            ramp_nxt  = cfg.max_level;
            hold_nxt  = 8'd1;
            for (int j = 0; j < NUM_STEPS; j++) begin
              if (lit_r[j]) lvl_nxt[j] = cfg.max_level;
            end
          end else begin
            pass_end = 1'b1;
          end
        end else begin
          // bottom sensor: upward travel
          if (item.motion_bottom && !lock_nxt[0]) begin
            if (!dir_nxt[0]) begin
              if (!lock_nxt[1]) begin
                lock_nxt[1] = 1'b1;
                timer_nxt   = '0;
              end
              dir_nxt[0]  = 1'b1;
              prog_nxt[0] = 1'b1;
            end
          end else if (dir_nxt[0]) begin
            dir_nxt[0]  = 1'b0;
            prog_nxt[1] = 1'b1;
          end
          // top sensor: downward travel, sees the bottom's lock update
          if (item.motion_top && !lock_nxt[1]) begin
            if (!dir_nxt[1]) begin
              if (!lock_nxt[0]) begin
                lock_nxt[0] = 1'b1;
                timer_nxt   = '0;
              end
              dir_nxt[1]  = 1'b1;
              prog_nxt[2] = 1'b1;
            end
          end else if (dir_nxt[1]) begin
            dir_nxt[1]  = 1'b0;
            prog_nxt[3] = 1'b1;
          end
          run_en   = 1'b1;
          run_from = 3'd0;
        end
      end else begin
        // ramp tick
        if (hold_r < cfg.level_ticks) begin
          hold_nxt = hold_r + 8'd1;
        end else begin
          if (phase_r != sls_pkg::PH_FADE && sls_pkg::seq_rises(cur_seq)) begin
            if (ramp_r >= cfg.max_level) done = 1'b1;
            else ramp_nxt = ramp_r + 8'd1;
          end else begin
            if (ramp_r == 8'd0) done = 1'b1;
            else ramp_nxt = ramp_r - 8'd1;
          end
          if (!done) begin
            hold_nxt = 8'd1;
            if (phase_r == sls_pkg::PH_FADE) begin
              for (int j = 0; j < NUM_STEPS; j++) begin
                if (lit_r[j]) lvl_nxt[j] = ramp_nxt;
              end
            end else begin
              lvl_nxt[idx_r[cur_seq]] = ramp_nxt;
            end
          end
        end

        if (done) begin
          if (phase_r == sls_pkg::PH_FADE) begin
            lit_nxt  = '0;
            for (int j = 0; j < NUM_STEPS; j++) lvl_nxt[j] = '0;
            dir_nxt  = 2'b00;
            prog_nxt = 4'b0000;
            idx_nxt[sls_pkg::SEQ_UP_ON]  = '0;
            idx_nxt[sls_pkg::SEQ_UP_OFF] = '0;
            idx_nxt[sls_pkg::SEQ_DN_ON]  = TOP_IDX;
            idx_nxt[sls_pkg::SEQ_DN_OFF] = TOP_IDX;
            pass_end = 1'b1;
          end else begin
            lit_nxt[idx_r[cur_seq]] = sls_pkg::seq_rises(cur_seq);
            if (idx_wraps(cur_seq, idx_r[cur_seq])) prog_nxt[cur_seq] = 1'b0;
            idx_nxt[cur_seq] = idx_step(cur_seq, idx_r[cur_seq]);
            run_en   = 1'b1;
            run_from = {1'b0, cur_seq} + 3'd1;
          end
        end
      end

      // serve remaining sequences in order, one step each
      if (run_en) begin
        for (int k = 0; k < 4; k++) begin
          if (!started && k >= int'(run_from) && prog_nxt[k]) begin
            if (lit_nxt[idx_nxt[k]] != sls_pkg::seq_rises(2'(k))) begin
              started   = 1'b1;
              phase_nxt = sls_pkg::seq_to_phase(2'(k));
              ramp_nxt  = sls_pkg::seq_rises(2'(k)) ? 8'd0 : cfg.max_level;
              hold_nxt  = 8'd1;
              lvl_nxt[idx_nxt[k]] = ramp_nxt;
            end else begin
              if (idx_wraps(2'(k), idx_nxt[k])) prog_nxt[k] = 1'b0;
              idx_nxt[k] = idx_step(2'(k), idx_nxt[k]);
            end
          end
        end
        if (!started) pass_end = 1'b1;
      end

      if (pass_end) begin
        phase_nxt = sls_pkg::PH_EVAL;
        if (lock_nxt != 2'b00 && timer_nxt > {1'b0, cfg.block_ticks}) begin
          lock_nxt  = 2'b00;
          timer_nxt = '0;
        end
      end
    end
  end

  // result of this tick
  assign result.ramp_busy = (phase_nxt != sls_pkg::PH_EVAL);

  for (genvar g = 0; g < sls_pkg::NUM_OUT; g++) begin : g_out
    if (g < NUM_STEPS) begin : g_used
      assign result.level[g] = lvl_nxt[g];
    end else begin : g_absent
      assign result.level[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r   <= '0;
      for (int j = 0; j < NUM_STEPS; j++) lvl_r[j] <= '0;
      idx_r[sls_pkg::SEQ_UP_ON]  <= '0;
      idx_r[sls_pkg::SEQ_UP_OFF] <= '0;
      idx_r[sls_pkg::SEQ_DN_ON]  <= TOP_IDX;
      idx_r[sls_pkg::SEQ_DN_OFF] <= TOP_IDX;
      prog_r  <= '0;
      dir_r   <= '0;
      lock_r  <= '0;
      timer_r <= '0;
      ramp_r  <= '0;
      hold_r  <= '0;
      phase_r <= sls_pkg::PH_EVAL;
    end else begin
      lit_r   <= lit_nxt;
      lvl_r   <= lvl_nxt;
      idx_r   <= idx_nxt;
      prog_r  <= prog_nxt;
      dir_r   <= dir_nxt;
      lock_r  <= lock_nxt;
      timer_r <= timer_nxt;
      ramp_r  <= ramp_nxt;
      hold_r  <= hold_nxt;
      phase_r <= phase_nxt;
    end
  end

  // a step ramp only runs for a sequence still in progress
  `ASSERT_IMPL(a_ramp_has_seq, clk, rst_n,
    phase_r != sls_pkg::PH_EVAL && phase_r != sls_pkg::PH_FADE,
    prog_r[sls_pkg::phase_to_seq(phase_r)])
  // only one direction can lock out the other
  `ASSERT_NEVER(a_single_lock, clk, rst_n, lock_r == 2'b11)
  // the timer is idle whenever no lock is held
  `ASSERT_IMPL(a_timer_idle, clk, rst_n, lock_r == 2'b00, timer_r == '0)

endmodule

@@ sv/sls_out_stage.sv @@
// Result register: holds one result transaction until the sink takes it.
module sls_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sls_pkg::result_t  result,
  sls_out_if.source         out_ch
);

  logic             valid_r, valid_nxt;
  sls_pkg::result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.level_step0 = res_r.level[0];
  assign out_ch.level_step1 = res_r.level[1];
  assign out_ch.level_step2 = res_r.level[2];
  assign out_ch.level_step3 = res_r.level[3];
  assign out_ch.level_step4 = res_r.level[4];
  assign out_ch.level_step5 = res_r.level[5];
  assign out_ch.level_step6 = res_r.level[6];
  assign out_ch.level_step7 = res_r.level[7];
  assign out_ch.ramp_busy   = res_r.ramp_busy;

endmodule

@@ test/tb_stair_light_sequencer_top.sv @@
// Self-checking testbench for stair_light_sequencer_top: tick stimulus, level tracking, checks.
module tb_stair_light_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS          = 8;
  localparam int LONG_HOLD      = 400;   // receiver hold-off used for back-pressure
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction

  // kinds of sensor activity held for a run of ticks
  typedef enum {
    EP_UP,
    EP_DOWN,
    EP_QUIET,
    EP_BOTH,
    EP_DAY,
    EP_NOISE
  } episode_e;

  // Tracks the stair state tick by tick and holds the step levels still to come out.
  class step_level_tracker;
    logic [7:0]                  max_level;
    logic [7:0]                  level_ticks;
    logic [15:0]                 block_ticks;
    logic                        lit[STEPS];
    logic [7:0]                  level[STEPS];
    int                          seq_ix[4];     // up-on, up-off, down-on, down-off
    logic [3:0]                  progress;
    logic [1:0]                  dir_on;        // bit0 upward, bit1 downward
    logic [1:0]                  locks;         // bit0 upward locked, bit1 downward locked
    logic [sls_pkg::TIMER_W-1:0] lock_timer;
    logic [7:0]                  ramp_level;
    logic [7:0]                  hold_cnt;
    sls_pkg::phase_e             phase;
    sls_pkg::result_t            levels_due[$];
    int                          errors;
    int                          checked;

    function new();
      max_level   = sls_pkg::MAX_LEVEL_RST;
      level_ticks = sls_pkg::LEVEL_TICKS_RST;
      block_ticks = sls_pkg::BLOCK_TICKS_RST;
      foreach (lit[j]) begin
        lit[j]   = 1'b0;
        level[j] = '0;
      end
      seq_ix     = '{0, 0, STEPS - 1, STEPS - 1};
      progress   = '0;
      dir_on     = '0;
      locks      = '0;
      lock_timer = '0;
      ramp_level = '0;
      hold_cnt   = '0;
      phase      = sls_pkg::PH_EVAL;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [sls_pkg::CFG_IDX_W-1:0] idx,
                            logic [sls_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sls_pkg::CFG_MAX_LEVEL:   max_level   = data[7:0];
        sls_pkg::CFG_LEVEL_TICKS: level_ticks = data[7:0];
        sls_pkg::CFG_BLOCK_TICKS: block_ticks = data;
        default: ;
      endcase
    endfunction

    function int slot_of(sls_pkg::phase_e ph);
      return int'(ph) - int'(sls_pkg::PH_UP_ON);
    endfunction

    function bit rises(int s);
      return (s == 0) || (s == 2);
    endfunction

    // upward sequences walk 0..7, downward ones 7..0; wrapping ends the sequence
    function void advance(int s);
      if (s < 2) begin
        if (seq_ix[s] >= STEPS - 1) begin
          seq_ix[s]   = 0;
          progress[s] = 1'b0;
        end else begin
          seq_ix[s]++;
        end
      end else begin
        if (seq_ix[s] == 0) begin
          seq_ix[s]   = STEPS - 1;
          progress[s] = 1'b0;
        end else begin
          seq_ix[s]--;
        end
      end
    endfunction

    function void write_level();
      if (phase == sls_pkg::PH_FADE) begin
        foreach (lit[j]) if (lit[j]) level[j] = ramp_level;
      end else begin
        level[seq_ix[slot_of(phase)]] = ramp_level;
      end
    endfunction

    // serve sequences from slot 'from' on; 1 when a ramp got started
    function bit start_ramps(int from);
      bit want;
      for (int s = from; s < 4; s++) begin
        if (!progress[s]) continue;
        want = rises(s);
        if (lit[seq_ix[s]] != want) begin
          phase      = sls_pkg::phase_e'(s + int'(sls_pkg::PH_UP_ON));
          ramp_level = want ? 8'd0 : max_level;
          hold_cnt   = 8'd1;
          write_level();
          return 1'b1;
        end
        advance(s);
      end
      return 1'b0;
    endfunction

    function void end_pass();
      phase = sls_pkg::PH_EVAL;
      if (locks != 0 && lock_timer > {1'b0, block_ticks}) begin
        locks      = '0;
        lock_timer = '0;
      end
    endfunction

    function bit at_rest();
      bit any;
      any = 1'b0;
      foreach (lit[j]) any |= lit[j];
      return phase == sls_pkg::PH_EVAL && !any && progress == 0 && dir_on == 0;
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    // one accepted tick; returns 1 when the sensors were looked at
    function bit take_tick(sls_pkg::item_t it);
      bit               sensed;
      bit               any;
      bit               done;
      int               s;
      sls_pkg::result_t r;
      sensed = (phase == sls_pkg::PH_EVAL);
      if (locks != 0 && lock_timer != sls_pkg::TIMER_MAX) lock_timer++;
      if (sensed) begin
        if (!it.is_dark) begin
          locks      = '0;
          lock_timer = '0;
          any        = 1'b0;
          foreach (lit[j]) any |= lit[j];
          if (any) begin
            phase      = sls_pkg::PH_FADE;
            ramp_level = max_level;
            hold_cnt   = 8'd1;
            write_level();
          end else begin
            end_pass();
          end
        end else begin
          if (it.motion_bottom && !locks[0]) begin
            if (!dir_on[0]) begin
              if (!locks[1]) begin
                locks[1]   = 1'b1;
                lock_timer = '0;
              end
              dir_on[0]   = 1'b1;
              progress[0] = 1'b1;
            end
          end else if (dir_on[0]) begin
            dir_on[0]   = 1'b0;
            progress[1] = 1'b1;
          end
          if (it.motion_top && !locks[1]) begin
            if (!dir_on[1]) begin
              if (!locks[0]) begin
                locks[0]   = 1'b1;
                lock_timer = '0;
              end
              dir_on[1]   = 1'b1;
              progress[2] = 1'b1;
            end
          end else if (dir_on[1]) begin
            dir_on[1]   = 1'b0;
            progress[3] = 1'b1;
          end
          if (!start_ramps(0)) end_pass();
        end
      end else if (hold_cnt < level_ticks) begin
        hold_cnt++;
      end else begin
        done = 1'b0;
        if (phase != sls_pkg::PH_FADE && rises(slot_of(phase))) begin
          if (ramp_level >= max_level) done = 1'b1;
          else ramp_level++;
        end else begin
          if (ramp_level == 0) done = 1'b1;
          else ramp_level--;
        end
        if (!done) begin
          hold_cnt = 8'd1;
          write_level();
        end else if (phase == sls_pkg::PH_FADE) begin
          foreach (lit[j]) begin
            lit[j]   = 1'b0;
            level[j] = '0;
          end
          dir_on   = '0;
          progress = '0;
          seq_ix   = '{0, 0, STEPS - 1, STEPS - 1};
          end_pass();
        end else begin
          s = slot_of(phase);
          lit[seq_ix[s]] = rises(s);
          advance(s);
          if (!start_ramps(s + 1)) end_pass();
        end
      end
      for (int j = 0; j < sls_pkg::NUM_OUT; j++) r.level[j] = level[j];
      r.ramp_busy = (phase != sls_pkg::PH_EVAL);
      levels_due.push_back(r);
      return sensed;
    endfunction

    function void check_levels(sls_pkg::result_t act);
      sls_pkg::result_t want;
      checked++;
      if (levels_due.size() == 0) begin
        $display("%0t: result transaction with no tick pending, busy %0b", $time,
                 act.ramp_busy);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      for (int j = 0; j < sls_pkg::NUM_OUT; j++) begin
        if (act.level[j] !== want.level[j]) begin
          $display("%0t: level_step%0d expected %0d actual %0d", $time, j,
                   want.level[j], act.level[j]);
          errors++;
        end
      end
      if (act.ramp_busy !== want.ramp_busy) begin
        $display("%0t: ramp_busy expected %0b actual %0b", $time, want.ramp_busy,
                 act.ramp_busy);
        errors++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [sls_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sls_pkg::CFG_DATA_W-1:0] cfg_wdata;

  sls_in_if  in_ch ();
  sls_out_if out_ch ();

  stair_light_sequencer_top #(.NUM_STEPS(STEPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  step_level_tracker tracker;

  bit steady;        // no gaps on either side while set
  bit hold_request;  // asks the receiver for one long hold-off
  int tick_cnt;
  int sensed_cnt;
  int setting_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sls_pkg::item_t mk(bit dark, bit bottom, bit top);
    sls_pkg::item_t it;
    it.is_dark       = dark;
    it.motion_bottom = bottom;
    it.motion_top    = top;
    return it;
  endfunction

  // Offer one tick; returns in the time step of its acceptance with valid still high,
  // so a back-to-back tick keeps valid up without a low pulse.
  task automatic send_tick(input sls_pkg::item_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.is_dark       <= it.is_dark;
    in_ch.motion_bottom <= it.motion_bottom;
    in_ch.motion_top    <= it.motion_top;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tick_cnt++;
    if (tracker.take_tick(it)) sensed_cnt++;
  endtask

  task automatic send_run(input sls_pkg::item_t it, input int n);
    repeat (n) send_tick(it);
  endtask

  // Stop offering and wait until every result is out; the block is then idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; junk in the unused upper byte.
  task automatic write_config(input logic [7:0] max_lvl, input logic [7:0] lvl_ticks,
                              input logic [15:0] blk_ticks);
    logic [15:0] d;
    d = {8'($urandom), max_lvl};
    cfg_we    <= 1'b1;
    cfg_index <= sls_pkg::CFG_MAX_LEVEL;
    cfg_wdata <= d;
    @(posedge clk);
    tracker.write_reg(sls_pkg::CFG_MAX_LEVEL, d);
    d = {8'($urandom), lvl_ticks};
    cfg_index <= sls_pkg::CFG_LEVEL_TICKS;
    cfg_wdata <= d;
    @(posedge clk);
    tracker.write_reg(sls_pkg::CFG_LEVEL_TICKS, d);
    cfg_index <= sls_pkg::CFG_BLOCK_TICKS;
    cfg_wdata <= blk_ticks;
    @(posedge clk);
    tracker.write_reg(sls_pkg::CFG_BLOCK_TICKS, blk_ticks);
    cfg_we <= 1'b0;
    setting_cnt++;
  endtask

  // Runs of sensor patterns: mostly up/down walks and quiet dark spells, some
  // daylight, both sensors at once and per-tick noise. Every tick sent counts toward n.
  task automatic random_phase(input int n, input bit do_hold, input bit do_pause);
    int             start;
    int             len;
    int             r;
    bit             mid_done;
    episode_e       ep;
    sls_pkg::item_t it;
    start    = tick_cnt;
    mid_done = 1'b0;
    while (tick_cnt - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 25) ep = EP_UP;
      else if (r < 50) ep = EP_DOWN;
      else if (r < 72) ep = EP_QUIET;
      else if (r < 80) ep = EP_BOTH;
      else if (r < 88) ep = EP_DAY;
      else ep = EP_NOISE;
      len = (ep == EP_DAY) ? $urandom_range(1, 4) : $urandom_range(1, 40);
      repeat (len) begin
        case (ep)
          EP_UP:    it = mk(1'b1, 1'b1, 1'b0);
          EP_DOWN:  it = mk(1'b1, 1'b0, 1'b1);
          EP_QUIET: it = mk(1'b1, 1'b0, 1'b0);
          EP_BOTH:  it = mk(1'b1, 1'b1, 1'b1);
          EP_DAY:   it = mk(1'b0, 1'($urandom), 1'($urandom));
          default:  it = sls_pkg::item_t'(3'($urandom));
        endcase
        send_tick(it);
        if (!mid_done && tick_cnt - start >= n / 2) begin
          mid_done = 1'b1;
          // receiver holds off long while ticks keep coming: block fills, input stalls
          if (do_hold) hold_request = 1'b1;
          // sender goes quiet until the pipeline has drained
          if (do_pause) settle();
        end
      end
    end
  endtask

  // Receiver: checks each result transaction, idles at random, honors long holds.
  initial begin
    int               stall_left;
    sls_pkg::result_t act;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        act.level[0]  = out_ch.level_step0;
        act.level[1]  = out_ch.level_step1;
        act.level[2]  = out_ch.level_step2;
        act.level[3]  = out_ch.level_step3;
        act.level[4]  = out_ch.level_step4;
        act.level[5]  = out_ch.level_step5;
        act.level[6]  = out_ch.level_step6;
        act.level[7]  = out_ch.level_step7;
        act.ramp_busy = out_ch.ramp_busy;
        tracker.check_levels(act);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, tracker.pending());
    $display("tb_stair_light_sequencer_top: FAIL");
    $finish;
  end

  initial begin
    int plan_max[9];
    int plan_ticks[9];
    int plan_block[9];
    int plan_n[9];
    plan_max     = '{1, 255, 0, 3, 0, 0, 0, 0, 2};
    plan_ticks   = '{1, 0, 255, 2, 0, 0, 0, 0, 0};
    plan_block   = '{0, 65535, 5, 20, 0, 0, 0, 0, 3};
    plan_n       = '{120, 60, 60, 120, 130, 130, 130, 130, 120};
    tracker      = new();
    steady       = 1'b0;
    hold_request = 1'b0;
    tick_cnt     = 0;
    sensed_cnt   = 0;
    setting_cnt  = 0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= sls_pkg::CFG_MAX_LEVEL;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.is_dark       <= 1'b0;
    in_ch.motion_bottom <= 1'b0;
    in_ch.motion_top    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: daylight with nothing lit (with and without
    // motion), dark and quiet, then both sensors at once: bottom wins, top locked out.
    send_tick(mk(1'b0, 1'b0, 1'b0));
    send_tick(mk(1'b0, 1'b1, 1'b1));
    send_tick(mk(1'b1, 1'b0, 1'b0));
    send_tick(mk(1'b1, 1'b1, 1'b1));
    // sensors are ignored while the long first ramp runs
    send_run(mk(1'b1, 1'b0, 1'b1), 3);
    settle();
    // new values land in the middle of that ramp; zero max level, zero lockout
    write_config(8'd0, 8'd1, 16'd0);
    send_run(mk(1'b1, 1'b1, 1'b0), 4);
    send_run(mk(1'b1, 1'b0, 1'b0), 4);
    settle();
    // zero level ticks, widest lockout, then daylight fades whatever is lit
    write_config(8'd2, 8'd0, 16'd65535);
    send_run(mk(1'b1, 1'b0, 1'b1), 4);
    send_run(mk(1'b0, 1'b0, 1'b0), 4);
    settle();

    // Random phases, each under its own register setting; extremes first.
    for (int p = 0; p < 9; p++) begin
      if (p >= 4 && p <= 7) begin
        plan_max[p]   = $urandom_range(0, 5);
        plan_ticks[p] = $urandom_range(0, 3);
        plan_block[p] = $urandom_range(0, 60);
      end
      write_config(8'(plan_max[p]), 8'(plan_ticks[p]), 16'(plan_block[p]));
      steady = (p >= 3) && ($urandom_range(0, 3) == 0);
      random_phase(plan_n[p], p == 0, p == 1);
      settle();
    end
    steady = 1'b0;

    // Bring the stairs to rest: dark quiet ticks and daylight until nothing is pending.
    while (!tracker.at_rest())
      send_tick($urandom_range(0, 1) ? mk(1'b1, 1'b0, 1'b0) : mk(1'b0, 1'b0, 1'b0));
    settle();

    // A fast upward ramp climbs well above one, then max level drops below the
    // running ramp level: the ramp ends at once; the top sensor then only lights
    // steps if the lock was released
    write_config(8'd200, 8'd0, 16'd100);
    send_run(mk(1'b1, 1'b1, 1'b0), 20);
    settle();
    write_config(8'd1, 8'd1, 16'd100);
    send_run(mk(1'b1, 1'b0, 1'b1), 60);
    send_run(mk(1'b0, 1'b0, 1'b0), 10);
    settle();

    tracker.errors += tracker.pending();
    $display("Covered %0d tick transactions (%0d sensor evaluations), %0d results checked,",
             tick_cnt, sensed_cnt, tracker.checked);
    $display("  %0d register settings incl. extremes, back-pressure and a mid-ramp level drop.",
             setting_cnt);
    if (tracker.errors == 0) begin
      $display("tb_stair_light_sequencer_top: PASS");
    end else begin
      $display("tb_stair_light_sequencer_top: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/sls_pkg.sv
sv/sls_in_if.sv
sv/sls_out_if.sv
sv/sls_in_stage.sv
sv/sls_step.sv
sv/sls_out_stage.sv
sv/stair_light_sequencer_top.sv
test/tb_stair_light_sequencer_top.sv
